[rtl/hbha_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Harmonic bond Hessian assembly package
// Shared widths, request codes and the status codes of the block.
// ----------------------------------------------------------------------------
package hbha_pkg;

  localparam int unsigned Nodes    = 64;
  localparam int unsigned NodeW    = 6;
  localparam int unsigned Dim      = 3 * Nodes;
  localparam int unsigned Cells    = Dim * Dim;
  localparam int unsigned AddrW    = $clog2(Cells);
  localparam int unsigned IdxW     = 8;
  localparam int unsigned EntryW   = 48;

  typedef enum logic [1:0] {
    REQ_CLEAR = 2'd0,
    REQ_ADD   = 2'd1,
    REQ_READ  = 2'd2,
    REQ_NOP   = 2'd3
  } req_e;

  localparam logic [1:0] StOk   = 2'd0;
  localparam logic [1:0] StZero = 2'd1;
  localparam logic [1:0] StSat  = 2'd2;

  typedef struct packed {
    logic [1:0]        req_type;
    logic [NodeW-1:0]  node_a;
    logic [NodeW-1:0]  node_b;
    logic signed [31:0] delta_x;
    logic signed [31:0] delta_y;
    logic signed [31:0] delta_z;
    logic [31:0]       spring_strength;
    logic [31:0]       rest_length;
    logic [IdxW-1:0]   read_row;
    logic [IdxW-1:0]   read_col;
  } req_t;

  typedef struct packed {
    logic signed [EntryW-1:0] entry_value;
    logic [1:0]               status;
  } rsp_t;

  // Request from the control unit to the matrix store.
  typedef struct packed {
    logic              we;
    logic [AddrW-1:0]  waddr;
    logic [EntryW-1:0] wdata;
    logic              re;
    logic [AddrW-1:0]  raddr;
  } mem_req_t;

endpackage

[rtl/hbha_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Harmonic bond Hessian assembly channel interfaces
// Valid/ready channels for requests and responses.
// ----------------------------------------------------------------------------
interface hbha_req_if;
  logic            valid;
  logic            ready;
  hbha_pkg::req_t  payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface hbha_rsp_if;
  logic            valid;
  logic            ready;
  hbha_pkg::rsp_t  payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

[rtl/hbha_store.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Harmonic bond Hessian matrix store
// Single-port-write, single-read synchronous memory with a registered read port.
// ----------------------------------------------------------------------------
module hbha_store (
  input  logic                           clk_i,
  input  hbha_pkg::mem_req_t             mreq_i,
  output logic [hbha_pkg::EntryW-1:0]    rdata_o
);

  logic [hbha_pkg::EntryW-1:0] mem_q [hbha_pkg::Cells];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (mreq_i.we) begin
      mem_q[mreq_i.waddr] <= mreq_i.wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (mreq_i.re) begin
      rdata_o <= mem_q[mreq_i.raddr];
    end
  end

endmodule

[rtl/hbha_divsqrt.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Harmonic bond Hessian iterative arithmetic unit
// Bit-serial square root of a 64-bit value (two bits a cycle) and restoring
// division of a 48-bit dividend by a 32-bit divisor (one bit a cycle).
// ----------------------------------------------------------------------------
module hbha_divsqrt (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        sqrt_start_i,
  input  logic [63:0] sqrt_arg_i,
  input  logic        div_start_i,
  input  logic [47:0] div_num_i,
  input  logic [31:0] div_den_i,
  output logic        busy_o,
  output logic [31:0] root_o,
  output logic [47:0] quot_o
);

  logic        sq_run_q, dv_run_q;
  logic [5:0]  cnt_q;
  logic [65:0] rem_q;
  logic [63:0] arg_q;
  logic [31:0] root_q;
  logic [47:0] num_q;
  logic [47:0] quo_q;
  logic [32:0] drem_q;
  logic [31:0] den_q;
  logic [65:0] trial;
  logic [65:0] rem_sh;
  logic [32:0] drem_sh;

  assign busy_o = sq_run_q | dv_run_q;
  assign root_o = root_q;
  assign quot_o = quo_q;

  // Trial subtraction for the digit-by-digit root.
  assign rem_sh = {rem_q[63:0], arg_q[63:62]};
  assign trial  = {32'd0, root_q, 2'b01};
  assign drem_sh = {drem_q[31:0], num_q[47]};

  // One root digit or one quotient bit a cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_run_q <= 1'b0;
      dv_run_q <= 1'b0;
      cnt_q    <= '0;
    end else if (sqrt_start_i) begin
      sq_run_q <= 1'b1;
      cnt_q    <= 6'd31;
    end else if (div_start_i) begin
      dv_run_q <= 1'b1;
      cnt_q    <= 6'd47;
    end else if (busy_o) begin
      cnt_q <= cnt_q - 6'd1;
      if (cnt_q == 6'd0) begin
        sq_run_q <= 1'b0;
        dv_run_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (sqrt_start_i) begin
      arg_q  <= sqrt_arg_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (sq_run_q) begin
      arg_q <= {arg_q[61:0], 2'b00};
      if (rem_sh >= trial) begin
        rem_q  <= rem_sh - trial;
        root_q <= {root_q[30:0], 1'b1};
      end else begin
        rem_q  <= rem_sh;
        root_q <= {root_q[30:0], 1'b0};
      end
    end
    if (div_start_i) begin
      num_q  <= div_num_i;
      den_q  <= div_den_i;
      drem_q <= '0;
      quo_q  <= '0;
    end else if (dv_run_q) begin
      num_q <= {num_q[46:0], 1'b0};
      if (drem_sh >= {1'b0, den_q}) begin
        drem_q <= drem_sh - {1'b0, den_q};
        quo_q  <= {quo_q[46:0], 1'b1};
      end else begin
        drem_q <= drem_sh;
        quo_q  <= {quo_q[46:0], 1'b0};
      end
    end
  end

endmodule

[rtl/hbha_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Harmonic bond Hessian assembly controller
// Sequences the bond arithmetic and the read-modify-write sweep of the
// store, the clearing pass, and matrix reads.
// ----------------------------------------------------------------------------
module hbha_ctrl (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  hbha_req_if.sink                    req,
  hbha_rsp_if.source                  rsp,
  output hbha_pkg::mem_req_t          mreq_o,
  input  logic [hbha_pkg::EntryW-1:0] rdata_i
);

  localparam int unsigned AW = hbha_pkg::AddrW;
  localparam logic signed [63:0] StMax = 64'sh0000_7FFF_FFFF_FFFF;
  localparam logic signed [63:0] StMin = -64'sh0000_8000_0000_0000;
  localparam logic [63:0] T2Cap = 64'h0000_8000_0000_0000;

  typedef enum logic [10:0] {
    S_INIT  = 11'b000_0000_0001,
    S_IDLE  = 11'b000_0000_0010,
    S_CLR   = 11'b000_0000_0100,
    S_SQRT  = 11'b000_0000_1000,
    S_DIV   = 11'b000_0001_0000,
    S_MUL   = 11'b000_0010_0000,
    S_TERM  = 11'b000_0100_0000,
    S_RD    = 11'b000_1000_0000,
    S_WR    = 11'b001_0000_0000,
    S_RDONE = 11'b010_0000_0000,
    S_OUT   = 11'b100_0000_0000
  } state_e;

  state_e state_q, state_d;

  logic [AW-1:0]  clr_q;
  hbha_pkg::req_t item_q;
  logic [2:0]     neg_q;
  logic [31:0]    mag_q [3];
  logic [63:0]    r2;
  logic [31:0]    r_q;
  logic [1:0]     dsel_q;
  logic [16:0]    um_q [3];
  logic [47:0]    qv_q;
  logic [32:0]    twok;
  logic [64:0]    plo_q;
  logic [81:0]    tprod;
  logic [63:0]    t2_q;
  logic [3:0]     el_q;
  logic [1:0]     upd_q;
  logic [1:0]     ek, el;
  logic [33:0]    uu_q;
  logic signed [63:0] term_q;
  logic           sat_q, zero_q;
  logic [7:0]     row, col;
  logic [AW-1:0]  addr_q;
  logic signed [63:0] cur, nxt;
  logic [47:0]    wval_q;
  logic           div_start, sqrt_start, busy;
  logic [31:0]    root;
  logic [47:0]    quot, dnum;
  logic [47:0]    rd_q;
  logic           rvalid_q;
  logic [1:0]     rstat_q;
  logic [64:0]    prod;
  logic [63:0]    off;
  logic signed [63:0] tval;

  hbha_divsqrt u_divsqrt (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .sqrt_start_i (sqrt_start),
    .sqrt_arg_i   (r2),
    .div_start_i  (div_start),
    .div_num_i    (dnum),
    .div_den_i    (r_q),
    .busy_o       (busy),
    .root_o       (root),
    .quot_o       (quot)
  );

  // Squared length from the captured magnitudes.
  assign r2 = 64'(mag_q[0]) * 64'(mag_q[0]) + 64'(mag_q[1]) * 64'(mag_q[1])
            + 64'(mag_q[2]) * 64'(mag_q[2]);
  assign twok = {item_q.spring_strength, 1'b0};
  assign dnum = (dsel_q == 2'd3) ? {item_q.rest_length, 16'd0}
                                 : {mag_q[dsel_q], 16'd0};
  assign sqrt_start = (state_q == S_SQRT) && !busy && !zero_q && (dsel_q == 2'd0);
  assign div_start  = (state_q == S_DIV) && !busy && (r_q != 32'd0) && (el_q == 4'd0);

  // Full 2k * q from the registered low half and the upper 16 bits of q.
  assign tprod = ((82'(twok) * 82'(qv_q[47:32])) << 32) + 82'(plo_q);

  assign ek = (el_q < 4'd3) ? 2'd0 : (el_q < 4'd6) ? 2'd1 : 2'd2;
  assign el = 2'(el_q - 4'(ek) * 4'd3);

  // Target of the current update: (a,a), (a,b), (b,a), (b,b).
  always_comb begin
    row = 8'(upd_q[1] ? item_q.node_b : item_q.node_a) * 8'd3 + 8'(ek);
    col = 8'(upd_q[0] ? item_q.node_b : item_q.node_a) * 8'd3 + 8'(el);
  end

  // Saturating update of the fetched entry.
  assign cur = 64'(signed'(rdata_i));
  assign nxt = (upd_q == 2'd1 || upd_q == 2'd2) ? cur - term_q : cur + term_q;

  // Off-diagonal product T2 * uu (T2 fits 48 bits, uu at most 1.0 in 17 bits).
  assign prod = 65'(t2_q[47:0]) * 65'(uu_q[16:0]);
  assign off  = 64'(prod >> 16);
  always_comb begin
    tval = (neg_q[ek] ^ neg_q[el]) ? -signed'(off) : signed'(off);
    if (ek == el) begin
      tval = tval + signed'({23'd0, twok, 8'd0}) - signed'(t2_q);
    end
  end

  assign req.ready = (state_q == S_IDLE) && !rvalid_q;
  assign rsp.valid = rvalid_q;
  assign rsp.payload.entry_value = rd_q;
  assign rsp.payload.status = rstat_q;

  always_comb begin
    mreq_o.we    = 1'b0;
    mreq_o.waddr = addr_q;
    mreq_o.wdata = wval_q;
    mreq_o.re    = 1'b0;
    mreq_o.raddr = AW'(32'(row) * hbha_pkg::Dim + 32'(col));
    case (state_q)
      S_INIT, S_CLR: begin
        mreq_o.we    = 1'b1;
        mreq_o.waddr = clr_q;
        mreq_o.wdata = '0;
      end
      S_WR:  mreq_o.we = 1'b1;
      S_TERM: mreq_o.re = 1'b1;
      S_IDLE: begin
        mreq_o.re    = 1'b1;
        mreq_o.raddr = AW'(32'(req.payload.read_row) * hbha_pkg::Dim
                           + 32'(req.payload.read_col));
      end
      default: ;
    endcase
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_INIT, S_CLR: if (clr_q == AW'(hbha_pkg::Cells - 1)) begin
        state_d = (state_q == S_CLR) ? S_OUT : S_IDLE;
      end
      S_IDLE: if (req.valid && req.ready) begin
        case (req.payload.req_type)
          hbha_pkg::REQ_CLEAR: state_d = S_CLR;
          hbha_pkg::REQ_ADD: begin
            if (32'(req.payload.node_a) >= hbha_pkg::Nodes) state_d = S_OUT;
            else if (32'(req.payload.node_b) >= hbha_pkg::Nodes) state_d = S_OUT;
            else state_d = S_SQRT;
          end
          hbha_pkg::REQ_READ: state_d = S_RDONE;
          default: state_d = S_OUT;
        endcase
      end
      S_SQRT: if (zero_q) state_d = S_DIV;
      S_DIV:  if (!busy && r_q == 32'd0) state_d = S_OUT;
              else if (el_q == 4'h9) state_d = S_MUL;
      S_MUL:  state_d = S_TERM;
      S_TERM: state_d = S_RD;
      S_RD:   state_d = S_WR;
      S_WR:   state_d = (upd_q == 2'd3) ? ((el_q == 4'd8) ? S_OUT : S_MUL) : S_TERM;
      S_RDONE: state_d = S_OUT;
      S_OUT:  state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_INIT;
      clr_q    <= '0;
      rvalid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_INIT || state_q == S_CLR) clr_q <= clr_q + 1'b1;
      else clr_q <= '0;
      if (state_q == S_OUT) rvalid_q <= 1'b1;
      else if (rsp.ready) rvalid_q <= 1'b0;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: if (req.valid && req.ready) begin
        item_q <= req.payload;
        neg_q  <= {req.payload.delta_z[31], req.payload.delta_y[31],
                   req.payload.delta_x[31]};
        mag_q[0] <= req.payload.delta_x[31] ? 32'(-req.payload.delta_x)
                                             : req.payload.delta_x;
        mag_q[1] <= req.payload.delta_y[31] ? 32'(-req.payload.delta_y)
                                             : req.payload.delta_y;
        mag_q[2] <= req.payload.delta_z[31] ? 32'(-req.payload.delta_z)
                                             : req.payload.delta_z;
        zero_q <= 1'b0;
        dsel_q <= 2'd0;
        sat_q  <= 1'b0;
        el_q   <= 4'd0;
        upd_q  <= 2'd0;
        rd_q   <= '0;
        rstat_q <= hbha_pkg::StOk;
      end
      S_SQRT: begin
        if (sqrt_start) dsel_q <= 2'd1;
        else if (dsel_q == 2'd1 && !busy) begin
          r_q    <= root;
          zero_q <= 1'b1;
          dsel_q <= 2'd0;
        end
      end
      S_DIV: begin
        if (!busy && r_q == 32'd0) rstat_q <= hbha_pkg::StZero;
        if (div_start) begin
          el_q[2:0] <= 3'(dsel_q) + 3'd1;
        end else if (!busy && el_q != 4'd0 && !el_q[3]) begin
          if (dsel_q == 2'd3) begin
            qv_q <= quot;
            el_q <= 4'd8;
          end else begin
            um_q[dsel_q] <= (quot > 48'd65536) ? 17'd65536 : quot[16:0];
            dsel_q <= dsel_q + 2'd1;
            el_q   <= 4'd0;
          end
        end
        if (el_q == 4'd8) begin
          // Low half of 2k * q; the upper bits of q join it in the next cycle.
          plo_q <= 65'(twok) * 65'(qv_q[31:0]);
          el_q  <= 4'h9;
        end
        if (el_q == 4'h9) begin
          // Form T2 and restart the element count.
          t2_q <= (tprod[81:8] > 74'(T2Cap)) ? T2Cap : 64'(tprod[81:8]);
          el_q <= 4'd0;
        end
      end
      S_MUL: begin
        uu_q  <= 34'((35'(um_q[ek]) * 35'(um_q[el])) >> 16);
        upd_q <= 2'd0;
      end
      S_TERM: begin
        if (upd_q == 2'd0) term_q <= tval;
        addr_q <= mreq_o.raddr;
      end
      S_RD: begin
        if (nxt > StMax) begin
          wval_q <= StMax[47:0];
          sat_q  <= 1'b1;
        end else if (nxt < StMin) begin
          wval_q <= StMin[47:0];
          sat_q  <= 1'b1;
        end else begin
          wval_q <= nxt[47:0];
        end
      end
      S_WR: begin
        upd_q <= upd_q + 2'd1;
        if (upd_q == 2'd3) begin
          el_q <= el_q + 4'd1;
          if (el_q == 4'd8) rstat_q <= (sat_q || nxt > StMax || nxt < StMin)
                                       ? hbha_pkg::StSat : hbha_pkg::StOk;
        end
      end
      S_RDONE: begin
        if (item_q.read_row < 8'(hbha_pkg::Dim) && item_q.read_col < 8'(hbha_pkg::Dim))
          rd_q <= rdata_i;
      end
      default: ;
    endcase
  end

endmodule

[rtl/harmonic_bond_hessian_assembly_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Harmonic bond Hessian assembly top level
// Accumulates harmonic spring Hessian blocks into a 192 x 192 matrix store.
// ----------------------------------------------------------------------------
// Channel  Dir  Beat contents
// req      in   request type, nodes, deltas, k, r0, read row/column
// rsp      out  entry value (Q24.24) and status
//
// An add runs a root, four divides, the two T2 steps, and nine matrix
// elements, each of one multiply step plus four store read-modify-writes
// (address, read, write). A read captures the addressed entry, then
// responds; a clear sweeps all 36864 entries, one a cycle.
// After reset the same clearing pass runs before the first request is taken.
// A stalled response holds the block; one request is in flight at a time.
module harmonic_bond_hessian_assembly_top (
  input logic        clk_i,
  input logic        rst_ni,
  hbha_req_if.sink   req,
  hbha_rsp_if.source rsp
);

  hbha_pkg::mem_req_t              mreq;
  logic [hbha_pkg::EntryW-1:0]     rdata;

  hbha_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req     (req),
    .rsp     (rsp),
    .mreq_o  (mreq),
    .rdata_i (rdata)
  );

  hbha_store u_store (
    .clk_i   (clk_i),
    .mreq_i  (mreq),
    .rdata_o (rdata)
  );

  // No request is taken while a response waits.
  a_no_take_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp.valid |-> !req.ready) else $error("request taken with response pending");

  // A response stays up until it is taken.
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp.valid && !rsp.ready |=> rsp.valid) else $error("response dropped");

  // Every response carries one of the defined status codes.
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp.valid |-> rsp.payload.status <= hbha_pkg::StSat) else $error("bad status code");

endmodule

[tb/sv/harmonic_bond_hessian_assembly_top_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Harmonic bond Hessian assembly testbench
// Drives clear, add, read and no-op requests into the block and checks every
// response beat against a bit-accurate Hessian store model or a hand-typed
// expectation. The run starts with a short directed table, then random traffic
// in four phases: no idling, sender idling, receiver stalling, and both.
// ----------------------------------------------------------------------------
module harmonic_bond_hessian_assembly_top_tb;
  import hbha_pkg::*;

  localparam int unsigned CycleLimit  = 8_000_000;
  localparam int unsigned PhaseBeats  = 500;
  localparam int unsigned DrainCycles = 600;
  localparam longint      EntryMax    = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint      EntryMin    = -EntryMax - 1;
  localparam logic [63:0] T2Cap       = 64'd1 << 47;

  // One row of the directed table; has_exp marks a hand-typed expectation.
  typedef struct {
    req_t beat;
    bit   has_exp;
    rsp_t exp;
  } dir_row_t;

  logic clk_i;
  logic rst_ni;

  hbha_req_if req_ch ();
  hbha_rsp_if rsp_ch ();

  harmonic_bond_hessian_assembly_top i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req    (req_ch),
    .rsp    (rsp_ch)
  );

  longint      hess_model [Cells];
  rsp_t        rsp_expected [$];
  int unsigned cycle_cnt;
  int unsigned err_cnt;
  int unsigned send_idle_pct;
  int unsigned rsp_stall_pct;
  int unsigned n_add, n_read, n_clear, n_sat, n_zero, n_rsp;
  logic [NodeW-1:0] recent_nodes [4];

  // Clock with a 2 ns period.
  always begin
    clk_i = 1'b1;
    #1;
    clk_i = 1'b0;
    #1;
  end

  // Cycle counter and run limit.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CycleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Integer square root of a Q32.32 value, giving Q16.16.
  function automatic logic [63:0] root64(logic [63:0] x);
    logic [63:0] rem, res, bitv;
    rem  = x;
    res  = '0;
    bitv = 64'd1 << 62;
    while (bitv > rem) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (rem >= res + bitv) begin
        rem = rem - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // Saturating update of one model entry; returns 1 when it clamps.
  function automatic bit hess_update(int unsigned row, int unsigned col,
                                     longint term, bit sub);
    longint v;
    v = sub ? hess_model[row * Dim + col] - term : hess_model[row * Dim + col] + term;
    if (v > EntryMax) begin
      hess_model[row * Dim + col] = EntryMax;
      return 1'b1;
    end
    if (v < EntryMin) begin
      hess_model[row * Dim + col] = EntryMin;
      return 1'b1;
    end
    hess_model[row * Dim + col] = v;
    return 1'b0;
  endfunction

  // Applies one request to the model store and returns its response.
  function automatic rsp_t hessian_predict(req_t p);
    rsp_t        r;
    logic [31:0] d [3];
    logic [63:0] mag [3];
    logic [63:0] um [3];
    bit          sgn [3];
    logic [63:0] r2, rlen, q, twok, t2, twok24, uu, off;
    logic [127:0] prod;
    longint      term;
    bit          sat;
    int unsigned a, b;
    r   = '0;
    sat = 1'b0;
    case (req_e'(p.req_type))
      REQ_CLEAR: begin
        foreach (hess_model[i]) hess_model[i] = 0;
      end
      REQ_READ: begin
        if (p.read_row < Dim && p.read_col < Dim)
          r.entry_value = hess_model[p.read_row * Dim + p.read_col][EntryW-1:0];
      end
      REQ_ADD: begin
        a  = 32'(p.node_a);
        b  = 32'(p.node_b);
        d[0] = p.delta_x;
        d[1] = p.delta_y;
        d[2] = p.delta_z;
        r2 = '0;
        for (int i = 0; i < 3; i++) begin
          sgn[i] = d[i][31];
          mag[i] = sgn[i] ? {32'd0, -d[i]} : {32'd0, d[i]};
          if (sgn[i] && mag[i] == 0) mag[i] = 64'd1 << 31;
          r2 = r2 + mag[i] * mag[i];
        end
        rlen = root64(r2);
        if (a >= Nodes || b >= Nodes) begin
          // Out-of-range nodes leave the store untouched.
        end else if (rlen == 0) begin
          r.status = StZero;
        end else begin
          for (int i = 0; i < 3; i++) begin
            um[i] = (mag[i] << 16) / rlen;
            if (um[i] > 64'd65536) um[i] = 64'd65536;
          end
          q    = ({32'd0, p.rest_length} << 16) / rlen;
          twok = {32'd0, p.spring_strength} * 2;
          prod = {64'd0, twok} * {64'd0, q};
          prod = prod >> 8;
          t2   = (prod > {64'd0, T2Cap}) ? T2Cap : prod[63:0];
          twok24 = twok << 8;
          for (int k = 0; k < 3; k++) begin
            for (int l = 0; l < 3; l++) begin
              uu   = (um[k] * um[l]) >> 16;
              off  = (t2 * uu) >> 16;
              term = (sgn[k] ^ sgn[l]) ? -longint'(off) : longint'(off);
              if (k == l) term = term + longint'(twok24) - longint'(t2);
              sat |= hess_update(a * 3 + k, a * 3 + l, term, 1'b0);
              sat |= hess_update(a * 3 + k, b * 3 + l, term, 1'b1);
              sat |= hess_update(b * 3 + k, a * 3 + l, term, 1'b1);
              sat |= hess_update(b * 3 + k, b * 3 + l, term, 1'b0);
            end
          end
          r.status = sat ? StSat : StOk;
        end
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  // Random signed coordinate difference, mostly of moderate size.
  function automatic logic [31:0] rand_delta();
    int unsigned sel;
    int unsigned span;
    sel = $urandom_range(0, 99);
    if (sel < 8) return '0;
    if (sel < 18) return $urandom();
    span = 1 << $urandom_range(4, 23);
    return $urandom_range(0, 2 * span) - span;
  endfunction

  // Random unsigned Q16.16 scalar, mostly small.
  function automatic logic [31:0] rand_scalar();
    if ($urandom_range(0, 9) == 0) return $urandom();
    return $urandom_range(0, 1 << $urandom_range(8, 22));
  endfunction

  // Random request; reads mostly target nodes of recent bonds.
  function automatic req_t rand_request();
    req_t        p;
    int unsigned sel;
    p          = '0;
    p.node_a   = NodeW'($urandom());
    p.node_b   = ($urandom_range(0, 15) == 0) ? p.node_a : NodeW'($urandom());
    p.delta_x  = rand_delta();
    p.delta_y  = rand_delta();
    p.delta_z  = rand_delta();
    p.spring_strength = rand_scalar();
    p.rest_length     = rand_scalar();
    if ($urandom_range(0, 6) == 0) begin
      p.read_row = IdxW'($urandom());
      p.read_col = IdxW'($urandom());
    end else begin
      p.read_row = IdxW'(recent_nodes[$urandom_range(0, 3)] * 3 + $urandom_range(0, 2));
      p.read_col = IdxW'(recent_nodes[$urandom_range(0, 3)] * 3 + $urandom_range(0, 2));
    end
    sel = $urandom_range(0, 999);
    if (sel < 4) p.req_type = REQ_CLEAR;
    else if (sel < 500) p.req_type = REQ_ADD;
    else if (sel < 940) p.req_type = REQ_READ;
    else p.req_type = REQ_NOP;
    if (p.req_type == REQ_ADD) begin
      recent_nodes[$urandom_range(0, 3)] = p.node_a;
      recent_nodes[$urandom_range(0, 3)] = p.node_b;
    end
    return p;
  endfunction

  // Sends one request beat, idling first at random, and books its response.
  task automatic send_request(req_t p, bit has_exp, rsp_t exp);
    rsp_t pred;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_ch.valid   <= 1'b1;
    req_ch.payload <= p;
    @(posedge clk_i);
    while (!req_ch.ready) @(posedge clk_i);
    pred = hessian_predict(p);
    rsp_expected.push_back(has_exp ? exp : pred);
    case (req_e'(p.req_type))
      REQ_ADD:   n_add++;
      REQ_READ:  n_read++;
      REQ_CLEAR: n_clear++;
      default: begin
      end
    endcase
  endtask

  // Holds the sender until every booked response has come back.
  task automatic drain_responses();
    req_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (rsp_expected.size() != 0) @(posedge clk_i);
  endtask

  // Response checker and receiver stall generator.
  always @(posedge clk_i or negedge rst_ni) begin
    rsp_t want;
    if (!rst_ni) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        n_rsp++;
        if (rsp_ch.payload.status == StSat) n_sat++;
        if (rsp_ch.payload.status == StZero) n_zero++;
        if (rsp_expected.size() == 0) begin
          $display("%0t: response beat with nothing expected: value %h status %0d",
                   $time, rsp_ch.payload.entry_value, rsp_ch.payload.status);
          err_cnt++;
        end else begin
          want = rsp_expected.pop_front();
          if (rsp_ch.payload.entry_value !== want.entry_value) begin
            $display("%0t: entry_value mismatch: expected %h actual %h",
                     $time, want.entry_value, rsp_ch.payload.entry_value);
            err_cnt++;
          end
          if (rsp_ch.payload.status !== want.status) begin
            $display("%0t: status mismatch: expected %0d actual %0d",
                     $time, want.status, rsp_ch.payload.status);
            err_cnt++;
          end
        end
      end
      rsp_ch.ready <= ($urandom_range(0, 99) >= rsp_stall_pct);
    end
  end

  // Main sequence: reset, directed table, random phases, drain and verdict.
  initial begin
    dir_row_t    dir_tab [$];
    dir_row_t    row;
    req_t        p;
    rsp_t        zero_rsp;
    rsp_t        zlen_rsp;
    int unsigned wait_cnt;
    zero_rsp = '0;
    zlen_rsp = '0;
    zlen_rsp.status = StZero;
    cycle_cnt = 0;
    err_cnt   = 0;
    n_add = 0; n_read = 0; n_clear = 0; n_sat = 0; n_zero = 0; n_rsp = 0;
    send_idle_pct = 0;
    rsp_stall_pct = 0;
    foreach (hess_model[i]) hess_model[i] = 0;
    foreach (recent_nodes[i]) recent_nodes[i] = NodeW'(i);
    rst_ni         = 1'b0;
    req_ch.valid   = 1'b0;
    req_ch.payload = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Read after reset, no-op and out-of-range reads read off directly.
    p = '0; p.req_type = REQ_READ; p.read_row = 8'd0; p.read_col = 8'd0;
    dir_tab.push_back('{p, 1'b1, zero_rsp});
    p = '1; p.req_type = REQ_NOP;
    dir_tab.push_back('{p, 1'b1, zero_rsp});
    // A zero-length bond is skipped with its flag.
    p = '0; p.req_type = REQ_ADD; p.node_a = 6'd1; p.node_b = 6'd2;
    p.spring_strength = 32'h0001_0000; p.rest_length = 32'h0001_0000;
    dir_tab.push_back('{p, 1'b1, zlen_rsp});
    // A unit bond along x, then reads of its blocks.
    p.delta_x = 32'h0001_0000;
    dir_tab.push_back('{p, 1'b0, zero_rsp});
    p = '0; p.req_type = REQ_READ; p.read_row = 8'd3; p.read_col = 8'd3;
    dir_tab.push_back('{p, 1'b0, zero_rsp});
    p.read_row = 8'd3; p.read_col = 8'd6;
    dir_tab.push_back('{p, 1'b0, zero_rsp});
    // Same node on both ends, with negative components.
    p = '0; p.req_type = REQ_ADD; p.node_a = 6'd5; p.node_b = 6'd5;
    p.delta_x = -32'sh0003_0000; p.delta_y = 32'h0004_0000; p.delta_z = -32'sh0000_8000;
    p.spring_strength = 32'h0002_0000; p.rest_length = 32'h0000_8000;
    dir_tab.push_back('{p, 1'b0, zero_rsp});
    p = '0; p.req_type = REQ_READ; p.read_row = 8'd15; p.read_col = 8'd16;
    dir_tab.push_back('{p, 1'b0, zero_rsp});
    // Extreme deltas with full-scale strength and length.
    p = '0; p.req_type = REQ_ADD; p.node_a = 6'd63; p.node_b = 6'd0;
    p.delta_x = 32'h8000_0000; p.delta_y = 32'h7FFF_FFFF; p.delta_z = 32'h8000_0000;
    p.spring_strength = '1; p.rest_length = '1;
    dir_tab.push_back('{p, 1'b0, zero_rsp});
    // Tiny length with full-scale strength drives entries into saturation.
    p.delta_x = 32'd1; p.delta_y = 32'd0; p.delta_z = 32'd0;
    dir_tab.push_back('{p, 1'b0, zero_rsp});
    dir_tab.push_back('{p, 1'b0, zero_rsp});
    p = '0; p.req_type = REQ_READ; p.read_row = 8'd189; p.read_col = 8'd189;
    dir_tab.push_back('{p, 1'b0, zero_rsp});
    p.read_row = 8'd191; p.read_col = 8'd0;
    dir_tab.push_back('{p, 1'b0, zero_rsp});
    p.read_row = 8'd192; p.read_col = 8'd0;
    dir_tab.push_back('{p, 1'b1, zero_rsp});
    p.read_row = 8'd255; p.read_col = 8'd255;
    dir_tab.push_back('{p, 1'b1, zero_rsp});
    // Zero strength and length, then a clear and a read of a touched entry.
    p = '0; p.req_type = REQ_ADD; p.node_a = 6'd2; p.node_b = 6'd3;
    p.delta_y = 32'hFFFF_0000; p.delta_z = 32'h0000_4000;
    dir_tab.push_back('{p, 1'b0, zero_rsp});
    p = '0; p.req_type = REQ_CLEAR;
    dir_tab.push_back('{p, 1'b1, zero_rsp});
    p = '0; p.req_type = REQ_READ; p.read_row = 8'd189; p.read_col = 8'd189;
    dir_tab.push_back('{p, 1'b1, zero_rsp});
    foreach (dir_tab[i]) begin
      row = dir_tab[i];
      send_request(row.beat, row.has_exp, row.exp);
    end
    drain_responses();

    // Random phases; the sender drains fully at each phase change.
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
        1: begin send_idle_pct = 52; rsp_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  rsp_stall_pct = 52; end
        default: begin send_idle_pct = 13; rsp_stall_pct = 13; end
      endcase
      for (int n = 0; n < PhaseBeats; n++) send_request(rand_request(), 1'b0, zero_rsp);
      drain_responses();
    end

    // Keep clocking for DrainCycles to catch any stray response beat.
    wait_cnt = 0;
    while (wait_cnt < DrainCycles) begin
      @(posedge clk_i);
      wait_cnt++;
    end

    $display("Covered %0d adds, %0d reads, %0d clears; %0d responses checked.",
             n_add, n_read, n_clear, n_rsp);
    $display("Saw %0d saturating adds and %0d zero-length bonds; %0d mismatches.",
             n_sat, n_zero, err_cnt);
    if (err_cnt == 0 && rsp_expected.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
